// ----- design/mns_pkg.sv -----
package mns_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;

   localparam int OP_W      = 3;
   localparam int INDEX_W   = 8;
   localparam int PITCH_W   = 13;
   localparam int CODE_W    = 8;
   localparam int ENTRY_W   = PITCH_W + CODE_W;
   localparam int TEMPO_W   = 10;
   localparam int COUNT_W   = 9;
   localparam int LEN_W     = 19;
   localparam int ELAPSED_W = 20;
   localparam int CSR_IDX_W = 2;

   // shared divider: widest dividend is the whole note, divisor tempo or code magnitude
   localparam int DIV_W     = 18;
   localparam int DIVISOR_W = 10;

   // sounding time is length * 9 / 10, taken by a multiply with a scaled reciprocal of ten
   // that is exact for every numerator below 2^23
   localparam int SOUND_NUM_W   = 23;
   localparam int SOUND_RECIP_W = 23;
   localparam int SOUND_PROD_W  = SOUND_NUM_W + SOUND_RECIP_W;
   localparam int SOUND_SHIFT   = 26;
   localparam int SOUND_RECIP   = 6710887;

   localparam int WHOLE_BASE  = 240000;
   localparam int SOUND_DIV   = 10;
   localparam int TEMPO_RESET = 120;

   localparam logic EVENT_NOTE   = 1'b0;
   localparam logic EVENT_FINISH = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 3'd0,
      OP_PLAY  = 3'd1,
      OP_PAUSE = 3'd2,
      OP_STOP  = 3'd3,
      OP_LOAD  = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMPO = 2'd0,
      CSR_COUNT = 2'd1,
      CSR_WAIT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic start_whole;
      logic start_note;
      logic start_sound_keep;
      logic start_sound_new;
      logic emit_note;
      logic emit_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic tick_fire;
      logic tick_finish;
      logic div_done;
      logic sound_done;
      logic code_zero;
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/mns_divider.sv -----
module mns_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mns_pkg::DIV_W-1:0]      dividend,
   input  logic [mns_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           done,
   output logic [mns_pkg::DIV_W-1:0]      quotient
);
   import mns_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     quo_in;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] rem_in;
   logic [DIVISOR_W-1:0] divisor_ff;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;
   logic                 take;

   // one restoring step a cycle, quotient bits shift in behind the dividend
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      take    = shifted >= {1'b0, divisor_ff};
      diff    = shifted - {1'b0, divisor_ff};
      rem_in  = take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_in  = {quo_ff[DIV_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/mns_datapath.sv -----
module mns_datapath #(
   parameter int TABLE_DEPTH = mns_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mns_pkg::OP_W-1:0]            req_operation,
   input  logic [mns_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [mns_pkg::PITCH_W-1:0]         req_entry_pitch,
   input  logic signed [mns_pkg::CODE_W-1:0]   req_entry_length_code,
   input  logic                                csr_write_enable,
   input  logic [mns_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mns_pkg::LEN_W-1:0]           csr_write_data,
   input  mns_pkg::ctrl_cmd_type               cmd,
   output mns_pkg::dp_status_type              status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_event_kind,
   output logic [mns_pkg::PITCH_W-1:0]         rsp_tone_pitch,
   output logic [mns_pkg::LEN_W-1:0]           rsp_sound_ms,
   output logic [mns_pkg::LEN_W-1:0]           rsp_slot_ms
);
   import mns_pkg::*;

   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int POS_W     = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W     = (POS_W > COUNT_W) ? POS_W : COUNT_W;
   localparam int IDX_CMP_W = (POS_W > INDEX_W) ? POS_W : INDEX_W;

   op_type op;

   logic [TEMPO_W-1:0]   tempo_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 playing_ff;
   logic                 playing_in;
   logic [POS_W-1:0]     pos_ff;
   logic [POS_W-1:0]     pos_in;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [ELAPSED_W-1:0] elapsed_in;
   logic [ELAPSED_W-1:0] elapsed_inc;
   logic [LEN_W-1:0]     cur_len_ff;
   logic [LEN_W-1:0]     cur_len_in;

   logic [ENTRY_W-1:0]   note_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0]   rd_entry_ff;
   logic                 load_en;

   logic [CMP_W-1:0]     count_ext;
   logic [CMP_W-1:0]     count_lim;
   logic                 at_end;
   logic                 len_reached;
   logic                 fire;

   logic [CODE_W-1:0]    code;
   logic [CODE_W-1:0]    code_mag;
   logic [LEN_W-1:0]     base_len;
   logic [LEN_W-1:0]     len_new;

   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quot;

   logic                    sound_start;
   logic [LEN_W-1:0]        sound_len;
   logic                    sound_go_ff;
   logic                    sound_done_ff;
   logic [SOUND_NUM_W-1:0]  sound_num_ff;
   logic [SOUND_PROD_W-1:0] sound_prod;
   logic [LEN_W-1:0]        sound_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_kind_ff;
   logic [PITCH_W-1:0]   rsp_pitch_ff;
   logic [LEN_W-1:0]     rsp_sound_ff;
   logic [LEN_W-1:0]     rsp_slot_ff;

   assign op = op_type'(req_operation);

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign len_reached = elapsed_inc >= {1'b0, cur_len_ff};
   assign fire        = (op == OP_TICK) && playing_ff && len_reached;

   assign count_ext = CMP_W'(count_ff);
   assign count_lim = (count_ext < CMP_W'(TABLE_DEPTH)) ? count_ext : CMP_W'(TABLE_DEPTH);
   assign at_end    = CMP_W'(pos_ff) >= count_lim;

   assign load_en = cmd.accept && (op == OP_LOAD) &&
                    (IDX_CMP_W'(req_entry_index) < IDX_CMP_W'(TABLE_DEPTH));

   always_comb begin
      playing_in = playing_ff;
      pos_in     = pos_ff;
      elapsed_in = elapsed_ff;
      if (cmd.accept) begin
         case (op)
            OP_TICK: begin
               elapsed_in = elapsed_inc;
               if (fire) begin
                  if (at_end) begin
                     playing_in = 1'b0;
                     pos_in     = '0;
                  end else begin
                     elapsed_in = '0;
                     pos_in     = pos_ff + 1'b1;
                  end
               end
            end
            OP_PLAY:  playing_in = 1'b1;
            OP_PAUSE: playing_in = 1'b0;
            OP_STOP: begin
               playing_in = 1'b0;
               pos_in     = '0;
            end
            default: ;
         endcase
      end
   end

   // note length from the whole-note quotient; dotted codes add half
   assign code     = rd_entry_ff[CODE_W-1:0];
   assign code_mag = code[CODE_W-1] ? (~code + 1'b1) : code;
   assign base_len = LEN_W'(div_quot);
   assign len_new  = code[CODE_W-1] ? (base_len + (base_len >> 1)) : base_len;

   always_comb begin
      cur_len_in = cur_len_ff;
      if (cmd.start_sound_new) begin
         cur_len_in = len_new;
      end else if (csr_write_enable && (csr_index == CSR_WAIT)) begin
         cur_len_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff   <= TEMPO_W'(TEMPO_RESET);
         count_ff   <= '0;
         playing_ff <= 1'b0;
         pos_ff     <= '0;
         elapsed_ff <= '0;
         cur_len_ff <= '0;
      end else begin
         playing_ff <= playing_in;
         pos_ff     <= pos_in;
         elapsed_ff <= elapsed_in;
         cur_len_ff <= cur_len_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TEMPO: tempo_ff <= csr_write_data[TEMPO_W-1:0];
               CSR_COUNT: count_ff <= csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         note_mem[AW'(req_entry_index)] <= {req_entry_pitch, req_entry_length_code};
      end
      if (cmd.accept) begin
         rd_entry_ff <= note_mem[pos_ff[AW-1:0]];
      end
   end

   assign div_start = cmd.start_whole | cmd.start_note;

   always_comb begin
      div_dividend = DIV_W'(WHOLE_BASE);
      div_divisor  = (tempo_ff == '0) ? DIVISOR_W'(1) : DIVISOR_W'(tempo_ff);
      if (cmd.start_note) begin
         div_dividend = div_quot;
         div_divisor  = DIVISOR_W'(code_mag);
      end
   end

   mns_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // sounding time: register length * 9, then multiply and take the scaled quotient
   assign sound_start = cmd.start_sound_keep | cmd.start_sound_new;
   assign sound_len   = cmd.start_sound_new ? len_new : cur_len_ff;
   assign sound_prod  = SOUND_PROD_W'(sound_num_ff) * SOUND_PROD_W'(SOUND_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_go_ff   <= 1'b0;
         sound_done_ff <= 1'b0;
      end else begin
         sound_go_ff   <= sound_start;
         sound_done_ff <= sound_go_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sound_start) begin
         sound_num_ff <= SOUND_NUM_W'({sound_len, 3'b000}) + SOUND_NUM_W'(sound_len);
      end
      if (sound_go_ff) begin
         sound_ff <= sound_prod[SOUND_SHIFT +: LEN_W];
      end
   end

   assign rsp_valid_in = (cmd.emit_note | cmd.emit_finish) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_note) begin
         rsp_kind_ff  <= EVENT_NOTE;
         rsp_pitch_ff <= rd_entry_ff[ENTRY_W-1:CODE_W];
         rsp_sound_ff <= sound_ff;
         rsp_slot_ff  <= cur_len_ff;
      end else if (cmd.emit_finish) begin
         rsp_kind_ff  <= EVENT_FINISH;
         rsp_pitch_ff <= '0;
         rsp_sound_ff <= '0;
         rsp_slot_ff  <= '0;
      end
   end

   assign status.tick_fire   = fire;
   assign status.tick_finish = at_end;
   assign status.div_done    = div_done;
   assign status.sound_done  = sound_done_ff;
   assign status.code_zero   = (code == '0);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_tone_pitch = rsp_pitch_ff;
   assign rsp_sound_ms   = rsp_sound_ff;
   assign rsp_slot_ms    = rsp_slot_ff;

endmodule

// ----- design/mns_ctrl.sv -----
module mns_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mns_pkg::dp_status_type status,
   output mns_pkg::ctrl_cmd_type  cmd
);
   import mns_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WHOLE,
      ST_NOTE,
      ST_SOUND,
      ST_EMIT_NOTE,
      ST_EMIT_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.tick_fire) begin
                  if (status.tick_finish) begin
                     state_in = ST_EMIT_FINISH;
                  end else begin
                     cmd.start_whole = 1'b1;
                     state_in        = ST_WHOLE;
                  end
               end
            end
         end
         ST_WHOLE: begin
            if (status.div_done) begin
               // zero code keeps the previous length
               if (status.code_zero) begin
                  cmd.start_sound_keep = 1'b1;
                  state_in             = ST_SOUND;
               end else begin
                  cmd.start_note = 1'b1;
                  state_in       = ST_NOTE;
               end
            end
         end
         ST_NOTE: begin
            if (status.div_done) begin
               cmd.start_sound_new = 1'b1;
               state_in            = ST_SOUND;
            end
         end
         ST_SOUND: begin
            if (status.sound_done) begin
               state_in = ST_EMIT_NOTE;
            end
         end
         ST_EMIT_NOTE: begin
            if (status.out_free) begin
               cmd.emit_note = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT_FINISH: begin
            if (status.out_free) begin
               cmd.emit_finish = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ----- design/melody_note_sequencer.sv -----
// Play, pause, stop, load, ignored codes and ticks that end no note leave the block idle.
// A tick that ends the melody moves to the finish emit state, which registers the event on rsp.
// A tick that starts a note runs two 18-step divisions, then registers length * 9 and the
// scaled product; a zero code skips the second division. No new request is taken until the
// event leaves its emit state, which waits while rsp holds a stalled event. Reset (synchronous,
// active high) stops play, clears position, elapsed time and length, sets tempo 120 and count 0.
module melody_note_sequencer #(
   parameter int TABLE_DEPTH = mns_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mns_pkg::OP_W-1:0]            req_operation,
   input  logic [mns_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [mns_pkg::PITCH_W-1:0]         req_entry_pitch,
   input  logic signed [mns_pkg::CODE_W-1:0]   req_entry_length_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_event_kind,
   output logic [mns_pkg::PITCH_W-1:0]         rsp_tone_pitch,
   output logic [mns_pkg::LEN_W-1:0]           rsp_sound_ms,
   output logic [mns_pkg::LEN_W-1:0]           rsp_slot_ms,
   input  logic                                csr_write_enable,
   input  logic [mns_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mns_pkg::LEN_W-1:0]           csr_write_data
);
   import mns_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mns_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_operation         (req_operation),
      .req_entry_index       (req_entry_index),
      .req_entry_pitch       (req_entry_pitch),
      .req_entry_length_code (req_entry_length_code),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .cmd                   (cmd),
      .status                (status),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_tone_pitch        (rsp_tone_pitch),
      .rsp_sound_ms          (rsp_sound_ms),
      .rsp_slot_ms           (rsp_slot_ms)
   );

endmodule

// ----- design/mns_checker.sv -----
module mns_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_event_kind,
   input logic [mns_pkg::PITCH_W-1:0]   rsp_tone_pitch,
   input logic [mns_pkg::LEN_W-1:0]     rsp_sound_ms,
   input logic [mns_pkg::LEN_W-1:0]     rsp_slot_ms
);
   import mns_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
      $stable(rsp_tone_pitch) && $stable(rsp_sound_ms) && $stable(rsp_slot_ms))
      else $error("rsp request changed while stalled");

   a_finish_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EVENT_FINISH) |->
      (rsp_tone_pitch == '0) && (rsp_sound_ms == '0) && (rsp_slot_ms == '0))
      else $error("finished event carries a note");

   a_sound_in_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EVENT_NOTE) |-> rsp_sound_ms <= rsp_slot_ms)
      else $error("tone longer than its slot");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid straight after reset");

endmodule

bind melody_note_sequencer mns_checker u_mns_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_kind (rsp_event_kind),
   .rsp_tone_pitch (rsp_tone_pitch),
   .rsp_sound_ms   (rsp_sound_ms),
   .rsp_slot_ms    (rsp_slot_ms)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import mns_pkg::*;

   localparam int LIMIT_CYCLES  = 3000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int DEPTH         = TABLE_DEPTH_DEFAULT;
   localparam int DEPTH_AW      = $clog2(DEPTH);
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 100;

   localparam int unsigned ELAPSED_MAX = (1 << ELAPSED_W) - 1;
   localparam int unsigned LEN_MAX     = (1 << LEN_W) - 1;
   localparam int unsigned PITCH_MAX   = (1 << PITCH_W) - 1;
   localparam int unsigned INDEX_MAX   = (1 << INDEX_W) - 1;
   localparam int unsigned CODE_MAX    = (1 << CODE_W) - 1;
   localparam int unsigned TEMPO_MAX   = (1 << TEMPO_W) - 1;
   localparam int unsigned COUNT_MAX   = (1 << COUNT_W) - 1;

   localparam logic [OP_W-1:0]      OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0]      OP_SPARE_LAST  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE      = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] slot_index;
      logic [PITCH_W-1:0] pitch;
      logic [CODE_W-1:0]  code;
   } note_request_type;

   typedef struct packed {
      logic               kind;
      logic [PITCH_W-1:0] pitch;
      logic [LEN_W-1:0]   sound;
      logic [LEN_W-1:0]   slot;
   } note_event_type;

   logic clock;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = '0;
   logic [INDEX_W-1:0]  req_entry_index = '0;
   logic [PITCH_W-1:0]  req_entry_pitch = '0;
   logic [CODE_W-1:0]   req_entry_length_code = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_event_kind;
   logic [PITCH_W-1:0]  rsp_tone_pitch;
   logic [LEN_W-1:0]    rsp_sound_ms;
   logic [LEN_W-1:0]    rsp_slot_ms;
   logic                csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LEN_W-1:0]    csr_write_data = '0;

   melody_note_sequencer #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_entry_index       (req_entry_index),
      .req_entry_pitch       (req_entry_pitch),
      .req_entry_length_code (req_entry_length_code),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_tone_pitch        (rsp_tone_pitch),
      .rsp_sound_ms          (rsp_sound_ms),
      .rsp_slot_ms           (rsp_slot_ms),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // player shadow
   int unsigned tempo_q    = TEMPO_RESET;
   int unsigned count_q    = 0;
   bit          playing_q  = 1'b0;
   int unsigned position_q = 0;
   int unsigned elapsed_q  = 0;
   int unsigned length_q   = 0;
   logic [ENTRY_W-1:0] note_mem [DEPTH];
   bit          load_queued [DEPTH];

   note_request_type queued_requests[$];
   note_event_type   expected_notes[$];
   note_event_type   seen_note;
   note_request_type next_request;

   bit          req_taken      = 1'b0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned phase_no       = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned note_length(logic [CODE_W-1:0] code, int unsigned prev);
      int unsigned whole;
      int unsigned d;
      whole = WHOLE_BASE / ((tempo_q == 0) ? 1 : tempo_q);
      if (code == '0) return prev;
      if (code[CODE_W-1]) begin
         // dotted: half as long again
         d = whole / (256 - code);
         d = d + (d >> 1);
      end else begin
         d = whole / code;
      end
      return d & LEN_MAX;
   endfunction

   task automatic advance_player(note_request_type r);
      note_event_type     ev;
      int unsigned        last;
      int unsigned        len;
      logic [ENTRY_W-1:0] entry;
      case (r.op)
         OP_PLAY:  playing_q = 1'b1;
         OP_PAUSE: playing_q = 1'b0;
         OP_STOP: begin
            playing_q  = 1'b0;
            position_q = 0;
         end
         OP_LOAD:  note_mem[DEPTH_AW'(r.slot_index)] = {r.pitch, r.code};
         OP_TICK: begin
            if (elapsed_q < ELAPSED_MAX) elapsed_q++;
            if (playing_q && elapsed_q >= length_q) begin
               last = (count_q < DEPTH) ? count_q : DEPTH;
               ev = '0;
               if (position_q >= last) begin
                  playing_q  = 1'b0;
                  position_q = 0;
                  ev.kind    = EVENT_FINISH;
               end else begin
                  entry      = note_mem[position_q[DEPTH_AW-1:0]];
                  len        = note_length(entry[CODE_W-1:0], length_q);
                  length_q   = len;
                  elapsed_q  = 0;
                  position_q++;
                  ev.kind    = EVENT_NOTE;
                  ev.pitch   = entry[ENTRY_W-1:CODE_W];
                  ev.sound   = LEN_W'(((len * (SOUND_DIV - 1)) / SOUND_DIV) & LEN_MAX);
                  ev.slot    = LEN_W'(len);
               end
               expected_notes.push_back(ev);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // accept requests and count cycles
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && req_ready) begin
         advance_player({req_operation, req_entry_index, req_entry_pitch,
                         req_entry_length_code});
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset && (req_taken || !req_valid)) begin
         req_taken = 1'b0;
         if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_request = queued_requests.pop_front();
            req_valid             <= 1'b1;
            req_operation         <= next_request.op;
            req_entry_index       <= next_request.slot_index;
            req_entry_pitch       <= next_request.pitch;
            req_entry_length_code <= next_request.code;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_notes.size() == 0) begin
            report_mismatch("note event with nothing expected");
         end else begin
            seen_note = expected_notes.pop_front();
            if (rsp_event_kind !== seen_note.kind)
               report_mismatch($sformatf("event_kind expected %0d got %0d",
                                         seen_note.kind, rsp_event_kind));
            if (rsp_tone_pitch !== seen_note.pitch)
               report_mismatch($sformatf("tone_pitch expected %0d got %0d",
                                         seen_note.pitch, rsp_tone_pitch));
            if (rsp_sound_ms !== seen_note.sound)
               report_mismatch($sformatf("sound_ms expected %0d got %0d",
                                         seen_note.sound, rsp_sound_ms));
            if (rsp_slot_ms !== seen_note.slot)
               report_mismatch($sformatf("slot_ms expected %0d got %0d",
                                         seen_note.slot, rsp_slot_ms));
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_TEMPO: tempo_q = 32'(data[TEMPO_W-1:0]);
         CSR_COUNT: count_q = 32'(data[COUNT_W-1:0]);
         CSR_WAIT:  length_q = 32'(data);
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                logic [PITCH_W-1:0] pitch, logic [CODE_W-1:0] code);
      note_request_type r;
      r.op         = op;
      r.slot_index = idx;
      r.pitch      = pitch;
      r.code       = code;
      if (op == OP_LOAD) load_queued[DEPTH_AW'(idx)] = 1'b1;
      queued_requests.push_back(r);
   endtask

   // other fields carry noise on commands and ticks
   task automatic queue_command(logic [OP_W-1:0] op);
      queue_request(op, INDEX_W'($urandom_range(INDEX_MAX)),
                    PITCH_W'($urandom_range(PITCH_MAX)), CODE_W'($urandom_range(CODE_MAX)));
   endtask

   task automatic queue_ticks(int n);
      repeat (n) queue_command(OP_TICK);
   endtask

   function automatic logic [CODE_W-1:0] pick_code();
      int unsigned roll;
      int unsigned mag;
      roll = $urandom_range(99);
      if (roll < 60) begin
         // large dividers keep notes short enough to see many of them
         mag = $urandom_range(128, 32);
         return $urandom_range(1) ? CODE_W'(256 - mag) : CODE_W'(mag);
      end
      if (roll < 70) return '0;
      return CODE_W'($urandom_range(CODE_MAX));
   endfunction

   task automatic fill_table(int unsigned n);
      int unsigned last;
      last = (n < DEPTH) ? n : DEPTH;
      for (int i = 0; i < last; i++)
         if (!load_queued[DEPTH_AW'(i)])
            queue_request(OP_LOAD, INDEX_W'(i), PITCH_W'($urandom_range(PITCH_MAX)),
                          pick_code());
   endtask

   task automatic queue_random_request();
      int unsigned     roll;
      logic [OP_W-1:0] op;
      roll = $urandom_range(99);
      if (roll < 68)      op = OP_TICK;
      else if (roll < 76) op = OP_PLAY;
      else if (roll < 80) op = OP_PAUSE;
      else if (roll < 83) op = OP_STOP;
      else if (roll < 97) op = OP_LOAD;
      else                op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      if (op == OP_LOAD)
         queue_request(op, INDEX_W'($urandom_range(INDEX_MAX)),
                       PITCH_W'($urandom_range(PITCH_MAX)), pick_code());
      else
         queue_command(op);
   endtask

   // wait until the block has gone quiet
   task automatic settle();
      while (!(queued_requests.size() == 0 && !req_valid && expected_notes.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling();
      case (phase_no % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
         default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      phase_no++;
   endtask

   task automatic begin_phase(int unsigned tempo, int unsigned count, int unsigned wait_ms);
      settle();
      set_idling();
      write_csr(CSR_TEMPO, LEN_W'(tempo));
      write_csr(CSR_COUNT, LEN_W'(count));
      write_csr(CSR_WAIT, LEN_W'(wait_ms));
      fill_table(count);
   endtask

   initial begin
      int unsigned roll;
      int unsigned tempo;
      int unsigned count;
      int unsigned wait_ms;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idling();

      // idle commands, spare codes, then finish with an empty melody
      queue_command(OP_TICK);
      queue_command(OP_PAUSE);
      queue_command(OP_STOP);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) queue_command(OP_W'(op));
      queue_command(OP_PLAY);
      queue_command(OP_PLAY);
      queue_command(OP_TICK);
      queue_command(OP_TICK);

      settle();
      write_csr(CSR_SPARE, LEN_W'(LEN_MAX));
      write_csr(CSR_TEMPO, LEN_W'(TEMPO_MAX));
      write_csr(CSR_COUNT, LEN_W'(4));
      write_csr(CSR_WAIT, LEN_W'(2));
      queue_request(OP_LOAD, INDEX_W'(0), PITCH_W'(PITCH_MAX), 8'sd127);
      queue_request(OP_LOAD, INDEX_W'(1), '0, -8'sd128);
      queue_request(OP_LOAD, INDEX_W'(2), PITCH_W'(1234), 8'sd0);
      queue_request(OP_LOAD, INDEX_W'(3), PITCH_W'(4321), -8'sd1);
      queue_command(OP_PLAY);
      queue_ticks(6);
      queue_command(OP_STOP);

      // slowest tempo: long notes, wide length values
      begin_phase(1, 2, 0);
      queue_request(OP_LOAD, INDEX_W'(0), PITCH_W'($urandom_range(PITCH_MAX)), -8'sd1);
      queue_request(OP_LOAD, INDEX_W'(1), PITCH_W'($urandom_range(PITCH_MAX)), 8'sd127);
      queue_command(OP_PLAY);
      queue_ticks(3);
      queue_command(OP_STOP);

      // zero tempo counts as one
      begin_phase(0, 1, 0);
      queue_request(OP_LOAD, INDEX_W'(0), PITCH_W'($urandom_range(PITCH_MAX)), 8'sd1);
      queue_command(OP_PLAY);
      queue_ticks(2);
      queue_command(OP_STOP);

      // longest initial wait holds the first note back
      begin_phase(TEMPO_MAX, 1, LEN_MAX);
      queue_command(OP_PLAY);
      queue_ticks(5);
      queue_command(OP_PAUSE);
      queue_command(OP_STOP);

      // note count above the table depth: play the whole table, then finish
      begin_phase(TEMPO_MAX, 0, 0);
      write_csr(CSR_COUNT, LEN_W'(COUNT_MAX));
      for (int i = 0; i < DEPTH; i++)
         queue_request(OP_LOAD, INDEX_W'(i), PITCH_W'($urandom_range(PITCH_MAX)),
                       $urandom_range(1) ? CODE_W'(256 - $urandom_range(127, 118))
                                         : CODE_W'($urandom_range(127, 118)));
      queue_command(OP_PLAY);
      queue_ticks(DEPTH + 6);
      queue_command(OP_STOP);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         roll    = $urandom_range(99);
         tempo   = (roll < 80) ? $urandom_range(TEMPO_MAX, 400) : $urandom_range(TEMPO_MAX, 1);
         count   = $urandom_range(40);
         roll    = $urandom_range(99);
         wait_ms = (roll < 88) ? $urandom_range(12) : $urandom_range(LEN_MAX);
         begin_phase(tempo, count, wait_ms);
         queue_command(OP_PLAY);
         repeat (PHASE_ITEMS) queue_random_request();
      end

      settle();
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
